@@ rtl/rpf_pkg.sv @@
package rpf_pkg;

    localparam int STEP_W   = 8;
    localparam int IDX_W    = 3;
    localparam int COLOR_W  = 16;
    localparam int CHAN_W   = 6;                 // widest channel (green)
    localparam int QUO_W    = 6;                 // |diff| * pos / total < 64
    localparam int PROD_W   = CHAN_W + STEP_W;
    localparam int ITER_W   = 3;
    localparam int PAL_SIZE = 7;

    localparam logic [ITER_W-1:0] ITER_LAST   = ITER_W'(QUO_W - 1);
    localparam logic [IDX_W-1:0]  PAL_LAST    = IDX_W'(PAL_SIZE - 1);
    localparam logic [STEP_W-1:0] STEPS_RESET = 8'd32;

    localparam logic [4:0] RED_MASK   = 5'h1F;
    localparam logic [5:0] GREEN_MASK = 6'h3F;
    localparam logic [4:0] BLUE_MASK  = 5'h1F;

    localparam logic [1:0] CH_RED = 2'd0;
    localparam logic [1:0] CH_GRN = 2'd1;
    localparam logic [1:0] CH_BLU = 2'd2;

    typedef logic [COLOR_W-1:0] t_color;

    typedef struct packed {
        logic       load;       // latch item, advance step / index
        logic       mul;        // form |diff| * pos for all channels
        logic       dvd_load;   // seed divider with product of channel ch
        logic       dvd_step;   // one quotient bit
        logic       dvd_store;  // keep quotient of channel ch
        logic [1:0] ch;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic bypass;           // pos >= total: end color, no division
        logic out_free;
    } t_sts;

    function automatic t_color pal_color(input logic [IDX_W-1:0] idx);
        t_color c;
        case (idx)
            3'd0:    c = 16'hF800;
            3'd1:    c = 16'hFC00;
            3'd2:    c = 16'hFFE0;
            3'd3:    c = 16'h07E0;
            3'd4:    c = 16'h001F;
            3'd5:    c = 16'h781F;
            3'd6:    c = 16'hF81F;
            default: c = 16'hF800;
        endcase
        return c;
    endfunction

    function automatic logic [CHAN_W-1:0] chan_get(input t_color c, input logic [1:0] ch);
        logic [CHAN_W-1:0] v;
        case (ch)
            CH_RED:  v = {1'b0, c[15:11] & RED_MASK};
            CH_GRN:  v = c[10:5] & GREEN_MASK;
            default: v = {1'b0, c[4:0] & BLUE_MASK};
        endcase
        return v;
    endfunction

endpackage

@@ rtl/rpf_run_if.sv @@
interface rpf_run_if;
    logic valid;
    logic ready;
    logic run;

    modport source (output valid, output run, input ready);
    modport sink   (input valid, input run, output ready);
endinterface

@@ rtl/rpf_color_if.sv @@
interface rpf_color_if;
    logic        valid;
    logic        ready;
    logic [15:0] color;
    logic [2:0]  palette_position;

    modport source (output valid, output color, output palette_position, input ready);
    modport sink   (input valid, input color, input palette_position, output ready);
endinterface

@@ rtl/rgb565_palette_fader.sv @@
// Channel    Dir  Handshake      Word
// i_run_ch   in   valid/ready    run (1)
// o_color_ch out  valid/ready    color (16), palette_position (3)
// i_cfg_*    in   write enable   steps_per_segment (8)
//
// A word with run set goes through a load, a multiply, then the shared
// restoring divider at one quotient bit per cycle: a divider load and six
// quotient bits for each of the three channels. When step >= steps per
// segment the divider is skipped. Words with run clear are taken and
// dropped. A held result does not block the next word, but that word's
// result then waits, and no further word is taken meanwhile. Reset is
// synchronous: step and palette index go to 0, steps per segment to 32.
module rgb565_palette_fader (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    rpf_run_if.sink            i_run_ch,
    rpf_color_if.source        o_color_ch
);
    import rpf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    rpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_run_ch.valid),
        .i_in_run   (i_run_ch.run),
        .o_in_ready (i_run_ch.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rpf_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (o_color_ch.ready),
        .o_out_valid (o_color_ch.valid),
        .o_out_color (o_color_ch.color),
        .o_out_pos   (o_color_ch.palette_position)
    );

endmodule

@@ rtl/rpf_ctrl.sv @@
module rpf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_run,
    output logic          o_in_ready,
    input  rpf_pkg::t_sts i_sts,
    output rpf_pkg::t_cmd o_cmd
);
    import rpf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_LDV  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [1:0]        r_ch, n_ch;

    always_comb begin
        n_state    = r_state;
        n_iter     = r_iter;
        n_ch       = r_ch;
        o_cmd      = '0;
        o_cmd.ch   = r_ch;
        o_in_ready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                // words with run clear are taken and dropped
                if (i_in_valid && i_in_run) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_ch      = CH_RED;
                n_state   = i_sts.bypass ? S_OUT : S_LDV;
            end
            S_LDV: begin
                o_cmd.dvd_load = 1'b1;
                n_iter         = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.dvd_step = 1'b1;
                n_iter         = r_iter + ITER_W'(1);
                if (r_iter == ITER_LAST) begin
                    o_cmd.dvd_store = 1'b1;
                    if (r_ch == CH_BLU) begin
                        n_state = S_OUT;
                    end else begin
                        n_ch    = r_ch + 2'd1;
                        n_state = S_LDV;
                    end
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
            r_ch    <= CH_RED;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_ch    <= n_ch;
        end
    end

endmodule

@@ rtl/rpf_datapath.sv @@
module rpf_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [7:0]             i_cfg_wdata,
    input  rpf_pkg::t_cmd          i_cmd,
    output rpf_pkg::t_sts          o_sts,
    input  logic                   i_out_ready,
    output logic                   o_out_valid,
    output logic [15:0]            o_out_color,
    output logic [2:0]             o_out_pos
);
    import rpf_pkg::*;

    // configuration and fade state
    logic [STEP_W-1:0] r_steps;
    logic [STEP_W-1:0] r_step_count;
    logic [IDX_W-1:0]  r_pal_idx;

    // latched item
    t_color            r_from, r_to;
    logic [STEP_W-1:0] r_pos, r_total;
    logic [IDX_W-1:0]  r_cur;

    // products and quotients per channel
    logic [PROD_W-1:0] r_prod_r, r_prod_g, r_prod_b;
    logic              r_neg_r, r_neg_g, r_neg_b;
    logic [QUO_W-1:0]  r_q_r, r_q_g, r_q_b;

    // shared divider
    logic [STEP_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [QUO_W-1:0]  r_dvd;

    logic              r_out_valid;
    t_color            r_out_color;
    logic [IDX_W-1:0]  r_out_pos;

    logic [IDX_W-1:0]  cur, nxt;
    logic [STEP_W:0]   bumped;
    logic [PROD_W-1:0] prod_sel;
    logic [STEP_W:0]   trial;
    logic              ge;
    logic [STEP_W-1:0] n_rem;
    logic [QUO_W-1:0]  n_quo;
    logic [CHAN_W-1:0] res_r, res_g, res_b;
    t_color            blend;

    assign cur    = (r_pal_idx > PAL_LAST) ? '0 : r_pal_idx;
    assign nxt    = (cur == PAL_LAST) ? '0 : cur + IDX_W'(1);
    assign bumped = {1'b0, r_step_count} + (STEP_W+1)'(1);

    always_comb begin
        case (i_cmd.ch)
            CH_RED:  prod_sel = r_prod_r;
            CH_GRN:  prod_sel = r_prod_g;
            default: prod_sel = r_prod_b;
        endcase
    end

    // restoring step; trial < 2*total, so the remainder fits 8 bits
    assign trial = {r_rem, r_dvd[QUO_W-1]};
    assign ge    = (trial >= {1'b0, r_total});
    assign n_rem = ge ? STEP_W'(trial - {1'b0, r_total}) : trial[STEP_W-1:0];
    assign n_quo = {r_quo[QUO_W-2:0], ge};

    function automatic logic [CHAN_W-1:0] apply(input logic [CHAN_W-1:0] f,
                                                input logic neg,
                                                input logic [QUO_W-1:0] q);
        return neg ? f - CHAN_W'(q) : f + CHAN_W'(q);
    endfunction

    assign res_r = apply(chan_get(r_from, CH_RED), r_neg_r, r_q_r);
    assign res_g = apply(chan_get(r_from, CH_GRN), r_neg_g, r_q_g);
    assign res_b = apply(chan_get(r_from, CH_BLU), r_neg_b, r_q_b);
    assign blend = {res_r[4:0], res_g, res_b[4:0]};

    function automatic logic [CHAN_W:0] mag_neg(input logic [CHAN_W-1:0] f,
                                                input logic [CHAN_W-1:0] t);
        logic neg;
        logic [CHAN_W-1:0] m;
        neg = (t < f);
        m   = neg ? f - t : t - f;
        return {neg, m};
    endfunction

    logic [CHAN_W:0] mn_r, mn_g, mn_b;
    assign mn_r = mag_neg(chan_get(r_from, CH_RED), chan_get(r_to, CH_RED));
    assign mn_g = mag_neg(chan_get(r_from, CH_GRN), chan_get(r_to, CH_GRN));
    assign mn_b = mag_neg(chan_get(r_from, CH_BLU), chan_get(r_to, CH_BLU));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps      <= STEPS_RESET;
            r_step_count <= '0;
            r_pal_idx    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_steps <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                if (bumped >= {1'b0, r_steps}) begin
                    r_step_count <= '0;
                    r_pal_idx    <= nxt;
                end else begin
                    r_step_count <= bumped[STEP_W-1:0];
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_from  <= pal_color(cur);
            r_to    <= pal_color(nxt);
            r_pos   <= r_step_count;
            r_total <= r_steps;
            r_cur   <= cur;
        end
        if (i_cmd.mul) begin
            r_neg_r  <= mn_r[CHAN_W];
            r_neg_g  <= mn_g[CHAN_W];
            r_neg_b  <= mn_b[CHAN_W];
            r_prod_r <= mn_r[CHAN_W-1:0] * r_pos;
            r_prod_g <= mn_g[CHAN_W-1:0] * r_pos;
            r_prod_b <= mn_b[CHAN_W-1:0] * r_pos;
        end
        // product < total * 64, so its upper bits already sit below total
        if (i_cmd.dvd_load) begin
            r_rem <= prod_sel[PROD_W-1:QUO_W];
            r_dvd <= prod_sel[QUO_W-1:0];
            r_quo <= '0;
        end else if (i_cmd.dvd_step) begin
            r_rem <= n_rem;
            r_dvd <= {r_dvd[QUO_W-2:0], 1'b0};
            r_quo <= n_quo;
        end
        if (i_cmd.dvd_store) begin
            case (i_cmd.ch)
                CH_RED:  r_q_r <= n_quo;
                CH_GRN:  r_q_g <= n_quo;
                default: r_q_b <= n_quo;
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_color <= o_sts.bypass ? r_to : blend;
            r_out_pos   <= r_cur;
        end
    end

    assign o_sts.bypass   = (r_pos >= r_total);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_color = r_out_color;
    assign o_out_pos   = r_out_pos;

endmodule

@@ rtl/rpf_checker.sv @@
module rpf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_run,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_color,
    input logic [2:0]  i_out_pos
);

    // a result waiting on the sink keeps its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_color) && $stable(i_out_pos))
        else $error("stalled result changed");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_pos <= 3'd6)
        else $error("palette position out of range");

    // a running word keeps the block busy for at least the next cycle
    a_busy_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_run |=> !i_in_ready)
        else $error("input taken while a word is in work");

    // a new result is only ever produced while the input side is busy
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared without work");

endmodule

bind rgb565_palette_fader rpf_checker u_rpf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_run_ch.valid),
    .i_in_ready  (i_run_ch.ready),
    .i_in_run    (i_run_ch.run),
    .i_out_valid (o_color_ch.valid),
    .i_out_ready (o_color_ch.ready),
    .i_out_color (o_color_ch.color),
    .i_out_pos   (o_color_ch.palette_position)
);

@@ tb/rgb565_palette_fader_tb.sv @@
`timescale 1ns / 100ps

module rgb565_palette_fader_tb;
    import rpf_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int TICK_TARGET   = 2000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;

    localparam t_color FADE_PALETTE [PAL_SIZE] = '{
        16'hF800, 16'hFC00, 16'hFFE0, 16'h07E0, 16'h001F, 16'h781F, 16'hF81F
    };

    typedef struct packed {
        t_color           color;
        logic [IDX_W-1:0] position;
    } t_fade_word;

    class fade_scoreboard;
        logic [STEP_W-1:0] seg_steps;
        logic [STEP_W-1:0] step;
        logic [IDX_W-1:0]  index;
        t_fade_word        expected_q[$];
        int                errors;

        function new();
            seg_steps = STEPS_RESET;
            step      = '0;
            index     = '0;
            errors    = 0;
        endfunction

        // C-style division: truncates toward zero for negative deltas
        function int mix(int from, int to);
            return from + ((to - from) * int'(step)) / int'(seg_steps);
        endfunction

        function t_color blend(t_color from, t_color to);
            int r, g, b;
            if (step >= seg_steps)
                return to;
            r = mix(from[15:11], to[15:11]);
            g = mix(from[10:5], to[10:5]);
            b = mix(from[4:0], to[4:0]);
            return {r[4:0], g[5:0], b[4:0]};
        endfunction

        function void note_tick(logic run);
            logic [IDX_W-1:0] cur;
            logic [IDX_W-1:0] nxt;
            t_fade_word       w;
            int               bumped;
            if (!run)
                return;
            cur = (index < PAL_SIZE) ? index : '0;
            nxt = (cur >= PAL_LAST) ? '0 : cur + 1'b1;
            w.color    = blend(FADE_PALETTE[cur], FADE_PALETTE[nxt]);
            w.position = cur;
            expected_q.push_back(w);
            // compare before truncation, so a step of 255 never wraps
            bumped = int'(step) + 1;
            if (bumped >= int'(seg_steps)) begin
                step  = '0;
                index = nxt;
            end else begin
                step = bumped[STEP_W-1:0];
            end
        endfunction

        function void check_word(t_color color, logic [IDX_W-1:0] position);
            t_fade_word w;
            if (expected_q.size() == 0) begin
                $error("unexpected word: color %h, palette_position %0d", color, position);
                errors++;
                return;
            end
            w = expected_q.pop_front();
            if (color !== w.color) begin
                $error("color: expected %h, actual %h", w.color, color);
                errors++;
            end
            if (position !== w.position) begin
                $error("palette_position: expected %0d, actual %0d", w.position, position);
                errors++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [STEP_W-1:0] cfg_wdata;

    fade_scoreboard sb;
    bit             no_idle   = 1'b0;
    int             hold_len  = 0;
    int             ticks_sent = 0;

    rpf_run_if   run_if ();
    rpf_color_if color_if ();

    rgb565_palette_fader i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_run_ch    (run_if),
        .o_color_ch  (color_if)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (color_if.valid === 1'b1 && color_if.ready === 1'b1)
                sb.check_word(color_if.color, color_if.palette_position);
            if (run_if.valid === 1'b1 && run_if.ready === 1'b1)
                sb.note_tick(run_if.run);
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int stall;
        color_if.ready <= 1'b0;
        @(negedge clk);
        forever begin
            if (hold_len > 0) begin
                stall    = hold_len;
                hold_len = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (stall > 0) begin
                color_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            color_if.ready <= 1'b1;
            do @(posedge clk); while (color_if.valid !== 1'b1);
            @(negedge clk);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((run_if.valid === 1'b1 && run_if.ready === 1'b1) ||
                (color_if.valid === 1'b1 && color_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** rgb565_palette_fader: FAILED **");
        $finish;
    end

    // starts and ends at a falling edge; valid stays up after the word
    task automatic send_tick(input logic run);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            run_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        run_if.valid <= 1'b1;
        run_if.run   <= run;
        do @(posedge clk); while (run_if.ready !== 1'b1);
        @(negedge clk);
        ticks_sent++;
    endtask

    task automatic drain();
        run_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        // a run-clear word may still be in flight
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_steps(input logic [STEP_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.seg_steps = value;
    endtask

    initial begin
        int phase;
        int n;
        logic [STEP_W-1:0] steps;
        sb = new();
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        run_if.valid <= 1'b0;
        run_if.run   <= 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset count, zero count, lowered count, extremes
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        write_steps(8'd0);
        repeat (8) send_tick(1'b1);
        write_steps(8'd20);
        repeat (6) send_tick(1'b1);
        write_steps(8'd3);
        repeat (2) send_tick(1'b1);
        write_steps(8'd1);
        repeat (2) send_tick(1'b1);
        write_steps(8'd255);
        repeat (3) send_tick(1'b1);
        send_tick(1'b0);

        phase = 0;
        while (ticks_sent < TICK_TARGET) begin
            case (phase % 8)
                0:       steps = 8'd0;
                1:       steps = 8'd255;
                2:       steps = 8'd1;
                3:       steps = STEP_W'($urandom_range(2, 8));
                4:       steps = STEP_W'($urandom_range(9, 40));
                5:       steps = STEP_W'($urandom_range(1, 255));
                6:       steps = 8'd2;
                default: steps = STEP_W'($urandom_range(3, 16));
            endcase
            write_steps(steps);
            no_idle = (phase % 5 == 2);
            if (phase == 3)
                hold_len = HOLD_CYCLES;
            n = $urandom_range(100, 200);
            for (int k = 0; k < n; k++) begin
                send_tick($urandom_range(0, 4) != 0);
                if (phase == 5 && k == n / 2)
                    drain();
            end
            phase++;
        end

        drain();
        if (sb.errors == 0)
            $display("** rgb565_palette_fader: PASSED **");
        else
            $display("** rgb565_palette_fader: FAILED **");
        $finish;
    end

endmodule
